>>> rtl/core/stw_pkg.sv
// ----------------------------------------------------------------------------
// stw_pkg: shared types and constants of the SIMD twister generator
// Pool geometry, lane masks, the controller-to-datapath command set and
// the 128-bit recursion used to rebuild one pool entry.
// ----------------------------------------------------------------------------
package stw_pkg;

  localparam int unsigned POOL_ENTRIES = 156;
  localparam int unsigned LANES        = 4;
  localparam int unsigned PICK_OFFSET  = 4;
  localparam int unsigned LANE_SHL     = 20;
  localparam logic [31:0] CHAIN_MUL    = 32'd1812433253;

  typedef logic [LANES-1:0][31:0] lanes_t;

  // Lane 3 first, so that lane 0 lands in the lowest 32 bits.
  localparam lanes_t LANE_MASK = {32'hedfefffd, 32'hcbfff7fe, 32'hffdff7fb, 32'hfffef7f9};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_RG_LOAD,
    ST_RG_PREV,
    ST_RG_READ,
    ST_RG_WRITE,
    ST_RD_ISSUE,
    ST_RD_OUT
  } state_e;

  typedef enum logic [1:0] {
    RD_SEL_IDX,
    RD_SEL_TAIL,
    RD_SEL_ENTRY
  } rd_sel_e;

  typedef struct packed {
    logic    seed_load;
    logic    seed_step;
    logic    prev_load;
    logic    regen_write;
    logic    idx_clear;
    logic    word_out;
    rd_sel_e rd_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic idx_wrapped;
    logic seed_last;
    logic regen_last;
  } dp_status_t;

  // One step of the recursion: a, a shifted up a byte, b shifted down a bit
  // and masked per lane, c down a byte and d up per lane, all XORed together.
  function automatic lanes_t twist(lanes_t a, lanes_t b, lanes_t c, lanes_t d);
    logic [127:0] av;
    logic [127:0] cv;
    lanes_t       r;
    av = a;
    cv = c;
    r  = (av << 8) ^ (cv >> 8) ^ av;
    for (int k = 0; k < LANES; k++) begin
      r[k] = r[k] ^ ((b[k] >> 1) & LANE_MASK[k]) ^ (d[k] << LANE_SHL);
    end
    return r;
  endfunction

endpackage

>>> rtl/core/stw_ctrl.sv
// ----------------------------------------------------------------------------
// stw_ctrl: sequencer of the SIMD twister generator
// Decodes each command beat and steps the datapath through seeding,
// pool regeneration and word read-out.
// ----------------------------------------------------------------------------
module stw_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  input  logic                   action_i,
  input  stw_pkg::dp_status_t    status_i,
  output logic                   busy,
  output stw_pkg::ctrl_cmd_t     cmd_o
);

  stw_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stw_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d            = state_q;
    cmd_o              = '0;
    cmd_o.rd_sel       = stw_pkg::RD_SEL_IDX;
    unique case (state_q)
      stw_pkg::ST_IDLE: begin
        if (start) begin
          if (!action_i) begin
            cmd_o.seed_load = 1'b1;
            state_d         = stw_pkg::ST_SEED;
          end else if (status_i.idx_wrapped) begin
            state_d = stw_pkg::ST_RG_LOAD;
          end else begin
            // The entry at the read index is already on the read port.
            state_d = stw_pkg::ST_RD_OUT;
          end
        end
      end
      stw_pkg::ST_SEED: begin
        cmd_o.seed_step = 1'b1;
        if (status_i.seed_last) begin
          state_d = stw_pkg::ST_IDLE;
        end
      end
      stw_pkg::ST_RG_LOAD: begin
        cmd_o.rd_sel = stw_pkg::RD_SEL_TAIL;
        state_d      = stw_pkg::ST_RG_PREV;
      end
      stw_pkg::ST_RG_PREV: begin
        cmd_o.prev_load = 1'b1;
        state_d         = stw_pkg::ST_RG_READ;
      end
      stw_pkg::ST_RG_READ: begin
        cmd_o.rd_sel = stw_pkg::RD_SEL_ENTRY;
        state_d      = stw_pkg::ST_RG_WRITE;
      end
      stw_pkg::ST_RG_WRITE: begin
        cmd_o.regen_write = 1'b1;
        if (status_i.regen_last) begin
          cmd_o.idx_clear = 1'b1;
          state_d         = stw_pkg::ST_RD_ISSUE;
        end else begin
          state_d = stw_pkg::ST_RG_READ;
        end
      end
      stw_pkg::ST_RD_ISSUE: begin
        state_d = stw_pkg::ST_RD_OUT;
      end
      stw_pkg::ST_RD_OUT: begin
        cmd_o.word_out = 1'b1;
        state_d        = stw_pkg::ST_IDLE;
      end
      default: begin
        state_d = stw_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != stw_pkg::ST_IDLE);

endmodule

>>> rtl/core/stw_datapath.sv
// ----------------------------------------------------------------------------
// stw_datapath: pool memory and arithmetic of the SIMD twister generator
// Holds the 128-bit pool, the read index, the seeding multiply chain and
// the regeneration recursion with its two previous results.
// ----------------------------------------------------------------------------
module stw_datapath #(
  parameter int unsigned PoolEntries = stw_pkg::POOL_ENTRIES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  stw_pkg::ctrl_cmd_t  cmd_i,
  input  logic [31:0]         seed_value_i,
  output stw_pkg::dp_status_t status_o,
  output logic [31:0]         random_word_o
);

  localparam int unsigned Words  = PoolEntries * stw_pkg::LANES;
  localparam int unsigned EntW   = $clog2(PoolEntries);
  localparam int unsigned IdxW   = $clog2(Words + 1);
  localparam int unsigned WrapAt = PoolEntries - stw_pkg::PICK_OFFSET;

  stw_pkg::lanes_t mem [PoolEntries];
  stw_pkg::lanes_t rd_a_q, rd_b_q;
  logic [EntW-1:0] addr_a, addr_b;
  logic            we;
  logic [EntW-1:0] waddr;
  stw_pkg::lanes_t wdata;

  logic [IdxW-1:0] idx_q;
  logic            seeded_q;
  logic [31:0]     chain_q;
  logic [IdxW-1:0] wcnt_q;
  stw_pkg::lanes_t buf_q, buf_d;
  logic [EntW-1:0] ent_q;
  stw_pkg::lanes_t prev2_q, prev1_q;

  logic [31:0]     mix, prod, chain_d;
  stw_pkg::lanes_t twist_res;
  logic [EntW-1:0] pick_addr;
  logic            idx_wrapped;

  // Seeding chain: one word a cycle.
  assign mix     = chain_q ^ (chain_q >> 30);
  assign prod    = mix * stw_pkg::CHAIN_MUL;
  assign chain_d = prod + 32'(wcnt_q);
  assign buf_d   = {chain_d, buf_q[stw_pkg::LANES-1:1]};

  assign twist_res   = stw_pkg::twist(rd_a_q, rd_b_q, prev2_q, prev1_q);
  assign idx_wrapped = (idx_q >= IdxW'(Words));
  assign pick_addr   = (ent_q >= EntW'(WrapAt)) ? (ent_q - EntW'(WrapAt))
                                                : (ent_q + EntW'(stw_pkg::PICK_OFFSET));

  always_comb begin
    addr_a = '0;
    addr_b = '0;
    unique case (cmd_i.rd_sel)
      stw_pkg::RD_SEL_IDX: begin
        addr_a = idx_wrapped ? '0 : EntW'(idx_q >> 2);
      end
      stw_pkg::RD_SEL_TAIL: begin
        addr_a = EntW'(PoolEntries - 2);
        addr_b = EntW'(PoolEntries - 1);
      end
      stw_pkg::RD_SEL_ENTRY: begin
        addr_a = ent_q;
        addr_b = pick_addr;
      end
      default: begin
        addr_a = '0;
      end
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = ent_q;
    wdata = twist_res;
    if (cmd_i.regen_write) begin
      we = 1'b1;
    end else if (cmd_i.seed_step && (wcnt_q[1:0] == 2'd3)) begin
      we    = 1'b1;
      waddr = EntW'(wcnt_q >> 2);
      wdata = buf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_q <= mem[addr_a];
    rd_b_q <= mem[addr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      seeded_q <= 1'b0;
      wcnt_q   <= '0;
      ent_q    <= '0;
    end else begin
      if (cmd_i.seed_load) begin
        wcnt_q <= IdxW'(1);
      end else if (cmd_i.seed_step) begin
        wcnt_q <= wcnt_q + IdxW'(1);
        if (status_o.seed_last) begin
          idx_q    <= IdxW'(Words);
          seeded_q <= 1'b1;
        end
      end
      if (cmd_i.prev_load) begin
        ent_q <= '0;
      end else if (cmd_i.regen_write) begin
        ent_q <= ent_q + EntW'(1);
      end
      if (cmd_i.idx_clear) begin
        idx_q <= '0;
      end else if (cmd_i.word_out) begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.seed_load) begin
      chain_q <= seed_value_i;
      buf_q   <= {seed_value_i, 96'b0};
    end else if (cmd_i.seed_step) begin
      chain_q <= chain_d;
      buf_q   <= buf_d;
    end
    if (cmd_i.prev_load) begin
      prev2_q <= rd_a_q;
      prev1_q <= rd_b_q;
    end else if (cmd_i.regen_write) begin
      prev2_q <= prev1_q;
      prev1_q <= twist_res;
    end
  end

  assign status_o.idx_wrapped = idx_wrapped;
  assign status_o.seed_last   = (wcnt_q == IdxW'(Words - 1));
  assign status_o.regen_last  = (ent_q == EntW'(PoolEntries - 1));

  // The pool is never cleared; until the first seed every word reads as zero,
  // which is also what regenerating an all-zero pool would give.
  assign random_word_o = seeded_q ? rd_a_q[idx_q[1:0]] : 32'd0;

endmodule

>>> rtl/core/simd_twister_rng_19937.sv
// ----------------------------------------------------------------------------
// simd_twister_rng_19937: 128-bit, four-lane twister pseudo-random word generator
// A next beat gives its word in the cycle after acceptance while unread words
// remain, and no new beat is taken until then; when the pool is used up it first
// regenerates, reading then writing each entry in turn. A seed beat runs one
// multiply-chain word per cycle, bound by the single multiplier.
// The single dual-read pool memory sets the regeneration rate. The receiver
// cannot stall: valid_o lasts one cycle. Reset clears control state only.
// ----------------------------------------------------------------------------
module simd_twister_rng_19937 #(
  parameter int unsigned PoolEntries = stw_pkg::POOL_ENTRIES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        action_i,
  input  logic [31:0] seed_value_i,
  output logic        valid_o,
  output logic [31:0] random_word_o
);

  stw_pkg::ctrl_cmd_t  cmd;
  stw_pkg::dp_status_t status;

  stw_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .action_i (action_i),
    .status_i (status),
    .busy     (busy),
    .cmd_o    (cmd)
  );

  stw_datapath #(
    .PoolEntries (PoolEntries)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .seed_value_i  (seed_value_i),
    .status_o      (status),
    .random_word_o (random_word_o)
  );

  assign valid_o = cmd.word_out;

endmodule

>>> tb/sv/simd_twister_rng_19937_tb.sv
// ----------------------------------------------------------------------------
// simd_twister_rng_19937_tb: self-checking bench for the SIMD twister generator
// Drives seed and next beats through the start/busy handshake, keeps its own
// copy of the 156-entry pool, predicts every random word and compares each
// strobed word in order. Covers reads of the unseeded pool, seed extremes, a
// run across a full pool wrap and a random mix of seeds and reads.
// ----------------------------------------------------------------------------
module simd_twister_rng_19937_tb;

  localparam int unsigned ENTRIES = stw_pkg::POOL_ENTRIES;
  localparam int unsigned WORDS   = 4 * ENTRIES;
  localparam int unsigned SETTLE  = 4 * ENTRIES + 16;
  localparam logic [31:0] SEED_MUL = 32'd1812433253;
  // Lane 0 sits in the lowest 32 bits.
  localparam logic [127:0] B_MASK = {32'hedfefffd, 32'hcbfff7fe, 32'hffdff7fb, 32'hfffef7f9};

  typedef enum logic {
    ACT_SEED = 1'b0,
    ACT_NEXT = 1'b1
  } action_e;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        action_i;
  logic [31:0] seed_value_i;
  logic        valid_o;
  logic [31:0] random_word_o;

  logic [127:0] pool_entry [ENTRIES];
  int unsigned  word_ptr;
  logic [31:0]  expected_words [$];
  int unsigned  error_count;
  bit           idling_on;

  simd_twister_rng_19937 u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .action_i      (action_i),
    .seed_value_i  (seed_value_i),
    .valid_o       (valid_o),
    .random_word_o (random_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(20 * 400000);
    $display("simd_twister_rng_19937_tb: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void seed_pool(logic [31:0] seed);
    logic [31:0] w;
    w = seed;
    pool_entry[0][31:0] = seed;
    for (int i = 1; i < WORDS; i++) begin
      w = SEED_MUL * (w ^ (w >> 30)) + i;
      pool_entry[i / 4][(i % 4) * 32 +: 32] = w;
    end
    word_ptr = WORDS;
  endfunction

  function automatic logic [127:0] twist_entry(logic [127:0] a, logic [127:0] b,
                                               logic [127:0] c, logic [127:0] d);
    logic [127:0] r;
    r = a ^ (a << 8) ^ (c >> 8);
    for (int k = 0; k < 4; k++) begin
      r[k * 32 +: 32] = r[k * 32 +: 32] ^ ((b[k * 32 +: 32] >> 1) & B_MASK[k * 32 +: 32])
                      ^ (d[k * 32 +: 32] << 20);
    end
    return r;
  endfunction

  function automatic void twist_pool();
    logic [127:0] two_back;
    logic [127:0] one_back;
    logic [127:0] r;
    two_back = pool_entry[ENTRIES - 2];
    one_back = pool_entry[ENTRIES - 1];
    for (int i = 0; i < ENTRIES; i++) begin
      r = twist_entry(pool_entry[i], pool_entry[(i + 4) % ENTRIES], two_back, one_back);
      pool_entry[i] = r;
      two_back = one_back;
      one_back = r;
    end
  endfunction

  function automatic logic [31:0] draw_word();
    logic [31:0] w;
    if (word_ptr >= WORDS) begin
      twist_pool();
      word_ptr = 0;
    end
    w = pool_entry[word_ptr / 4][(word_ptr % 4) * 32 +: 32];
    word_ptr = (word_ptr + 1) & 10'h3ff;
    return w;
  endfunction

  // ------------------------------------------------------------------ checker

  task automatic report_error(string what, logic [31:0] exp_word, logic [31:0] got_word);
    if (error_count < 10) begin
      $display("%s: expected %08h, got %08h", what, exp_word, got_word);
    end
    error_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && valid_o !== 1'b0) begin
      if (expected_words.size() == 0) begin
        report_error("random_word with nothing pending", 32'hx, random_word_o);
      end else begin
        if (random_word_o !== expected_words[0]) begin
          report_error("random_word mismatch", expected_words[0], random_word_o);
        end
        void'(expected_words.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  // Leaves start high after the beat, so a following call can present the
  // next beat at the very edge that accepted this one.
  task automatic send_item(action_e act, logic [31:0] seed);
    if (idling_on && $urandom_range(0, 99) < 13) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    start        <= 1'b1;
    action_i     <= act;
    seed_value_i <= seed;
    do @(posedge clk_i); while (busy !== 1'b0);
    if (act == ACT_SEED) begin
      seed_pool(seed);
    end else begin
      expected_words.push_back(draw_word());
    end
  endtask

  // Before any seed the pool reads as zeros.
  task automatic test_unseeded_pool();
    for (int n = 0; n < 8; n++) begin
      send_item(ACT_NEXT, (n % 2 == 0) ? 32'h0 : 32'hffffffff);
    end
  endtask

  task automatic test_seed_extremes();
    send_item(ACT_SEED, 32'h0);
    for (int n = 0; n < 3; n++) send_item(ACT_NEXT, 32'hffffffff);
    send_item(ACT_SEED, 32'hffffffff);
    for (int n = 0; n < 3; n++) send_item(ACT_NEXT, 32'h0);
    // A second seed right after the first must fully replace it.
    send_item(ACT_SEED, 32'h80000001);
    send_item(ACT_SEED, 32'h12345678);
    send_item(ACT_NEXT, 32'h5a5a5a5a);
    send_item(ACT_NEXT, 32'ha5a5a5a5);
  endtask

  // One seed, then enough reads to use up the pool and twist it again.
  task automatic test_long_run();
    send_item(ACT_SEED, $urandom());
    for (int n = 0; n < WORDS + 6; n++) begin
      idling_on = (n < 200 || n >= 400);
      send_item(ACT_NEXT, $urandom());
    end
    idling_on = 1'b1;
  endtask

  task automatic test_mixed_run();
    for (int n = 0; n < 80; n++) begin
      send_item(($urandom_range(0, 7) == 0) ? ACT_SEED : ACT_NEXT, $urandom());
    end
  endtask

  initial begin
    start        = 1'b0;
    action_i     = 1'b0;
    seed_value_i = 32'h0;
    rst_ni       = 1'b0;
    error_count  = 0;
    idling_on    = 1'b1;
    word_ptr     = 0;
    for (int i = 0; i < ENTRIES; i++) pool_entry[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_unseeded_pool();
    test_seed_extremes();
    test_long_run();
    test_mixed_run();

    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    if (error_count == 0 && expected_words.size() == 0) begin
      $display("simd_twister_rng_19937_tb: done, clean");
    end else begin
      $display("simd_twister_rng_19937_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/stw_pkg.sv
rtl/core/stw_ctrl.sv
rtl/core/stw_datapath.sv
rtl/core/simd_twister_rng_19937.sv
tb/sv/simd_twister_rng_19937_tb.sv
